// File: sv/ird_pkg.sv
// Shared types and constants for the infrared delivery code transmitter.
// Depends on nothing; every other file imports it.
package ird_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned SEG_IDX_W = 6;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0] HEADER_BYTE = 8'hA5;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 1'b1;

    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd1440;
    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd360;

    typedef struct packed {
        logic             func;
        logic [NIB_W-1:0] param_a;
        logic [NIB_W-1:0] param_b;
        logic [NIB_W-1:0] param_c;
        logic [NIB_W-1:0] param_d;
    } cmd_item_t;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic accepted;
        logic done_res;
    } rsp_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] short_ticks;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0]    code_word;
        logic [SEG_IDX_W-1:0] seg_idx;
        logic [TICK_W-1:0]    tick_count;
        logic                 carrier_phase;
        logic                 carrier_enable;
        logic                 sending;
    } tx_state_t;

endpackage

// File: sv/ird_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on ird_pkg for the payload types.
interface ird_cmd_if
    import ird_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ird_rsp_if
    import ird_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ir_delivery_code_transmitter_core.sv
// Top level of the infrared delivery code transmitter: input register, state,
// result register. Depends on ird_pkg, ird_if, ird_cfg_regs and ird_step.
//
//   channel | dir | payload                                  | handshake
//   --------+-----+------------------------------------------+-------------
//   cmd     | in  | func, param_a..param_d                   | valid/ready
//   rsp     | out | ir_level, busy_res, accepted, done_res   | valid/ready
//   cfg     | in  | cfg_index, cfg_wdata                     | cfg_we only
//
// One item per cycle sustained while rsp is ready; an item passes the input
// register, then the result register, and its result shows on rsp from the
// result register.
// The state update sits between the two registers and happens when an item
// moves out of the input register. Reset is asynchronous, active low, and
// leaves the block idle with the carrier off. A stalled rsp holds its result;
// cmd stays ready while the input register can drain into the result register.
module ir_delivery_code_transmitter_core
    import ird_pkg::*;
#(
    parameter int unsigned SEGMENTS = 33
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ird_cmd_if.sink               cmd,
    ird_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg;

    // Input register
    logic      in_valid_reg;
    logic      in_valid_next;
    cmd_item_t in_item_reg;

    // Transmitter state
    tx_state_t state_reg;
    tx_state_t state_next;

    // Result register
    logic      res_valid_reg;
    logic      res_valid_next;
    rsp_item_t res_item_reg;
    rsp_item_t step_result;

    logic      advance;
    logic      cmd_fire;

    ird_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ird_step #(
        .SEGMENTS (SEGMENTS)
    ) u_step (
        .st      (state_reg),
        .item    (in_item_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .result  (step_result)
    );

    // Advance the held item whenever the result register is free or draining
    assign advance   = in_valid_reg && (!res_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            in_item_reg <= cmd.data;
        end
        if (advance)
        begin
            res_item_reg <= step_result;
        end
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.data  = res_item_reg;

`ifndef SYNTHESIS
    // State moves only when an item passes into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("transmitter state changed without an item");

    // Ending the last segment leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_result.done_res) |=> !state_reg.sending)
        else $error("still sending after the last segment");

    // Segment index never passes the last segment
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seg_idx <= SEG_IDX_W'(SEGMENTS - 1))
        else $error("segment index out of range");

    // A full pipeline with a stalled result refuses new items
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && res_valid_reg && !rsp.ready) |-> !cmd.ready)
        else $error("item taken while both stages are full and stalled");
`endif

endmodule

// File: sv/ird_cfg_regs.sv
// Segment length registers behind the plain write port.
// Depends on ird_pkg.
module ird_cfg_regs
    import ird_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_TICKS:  cfg_next.long_ticks  = cfg_wdata;
                CFG_SHORT_TICKS: cfg_next.short_ticks = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_ticks  <= LONG_TICKS_RST;
            cfg_reg.short_ticks <= SHORT_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/ird_step.sv
// Next-state and result logic for one item: word build, tick count, segment end.
// Depends on ird_pkg.
module ird_step
    import ird_pkg::*;
#(
    parameter int unsigned SEGMENTS = 33
)
(
    input  tx_state_t st,
    input  cmd_item_t item,
    input  cfg_t      cfg,
    output tx_state_t st_next,
    output rsp_item_t result
);

    localparam logic [SEG_IDX_W-1:0] LAST_SEG = SEG_IDX_W'(SEGMENTS - 1);

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] seg_len;
    logic              seg_end;
    logic              bit_is_one;
    logic [7:0]        check_byte;

    // Segments from bit 32 on are always short
    assign bit_is_one = (st.seg_idx < SEG_IDX_W'(WORD_W))
                        && st.code_word[st.seg_idx[4:0]];
    assign seg_len    = bit_is_one ? cfg.long_ticks : cfg.short_ticks;
    assign tick_inc   = st.tick_count + 1'b1;
    // A zero length register behaves as one tick
    assign seg_end    = (tick_inc >= seg_len) || (tick_inc == '0);
    assign check_byte = {item.param_d, item.param_c} ^ {item.param_b, item.param_a};

    always_comb
    begin
        st_next         = st;
        result.accepted = 1'b0;
        result.done_res = 1'b0;
        if (item.func == FUNC_REQUEST)
        begin
            if (!st.sending)
            begin
                st_next.code_word      = {HEADER_BYTE, item.param_d, item.param_c,
                                          item.param_b, item.param_a, check_byte};
                st_next.seg_idx        = '0;
                st_next.tick_count     = '0;
                st_next.carrier_phase  = 1'b0;
                st_next.carrier_enable = 1'b1;
                st_next.sending        = 1'b1;
                result.accepted        = 1'b1;
            end
        end
        else if (st.sending)
        begin
            st_next.carrier_phase = st.carrier_enable ? ~st.carrier_phase : 1'b0;
            st_next.tick_count    = tick_inc;
            if (seg_end)
            begin
                st_next.tick_count = '0;
                if (st.seg_idx >= LAST_SEG)
                begin
                    st_next.seg_idx        = '0;
                    st_next.sending        = 1'b0;
                    st_next.carrier_enable = 1'b0;
                    st_next.carrier_phase  = 1'b0;
                    result.done_res        = 1'b1;
                end
                else
                begin
                    st_next.seg_idx        = st.seg_idx + 1'b1;
                    st_next.carrier_enable = ~st.carrier_enable;
                    if (st.carrier_enable)
                    begin
                        st_next.carrier_phase = 1'b0;
                    end
                end
            end
        end
        result.ir_level = st_next.carrier_enable & st_next.sending & st_next.carrier_phase;
        result.busy_res = st_next.sending;
    end

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for ir_delivery_code_transmitter_core: directed and random
// request/tick traffic, checked against a behavioural transmitter model.
// Depends on ird_pkg, ird_if and the core RTL.
module tb import ird_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Segment count matches the core default; the model reads it too.
    localparam int unsigned SEGMENT_COUNT = 33;
    // Far above the slowest correct run, in which every item waits out random
    // sender gaps and receiver stalls.
    localparam int unsigned CYCLE_LIMIT   = 500000;
    // Margin after the last result; results pass the input and result registers.
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ird_cmd_if cmd_ch ();
    ird_rsp_if rsp_ch ();

    // Behavioural copy of the transmitter state and its segment lengths.
    tx_state_t tx;
    cfg_t      seg_len;

    // Results predicted for accepted items, oldest first.
    rsp_item_t pending_responses [$];

    int unsigned mismatch_count = 0;
    int unsigned live_items     = 0;    // items that start or advance a code
    int unsigned cycle_count    = 0;
    int unsigned cmd_gap_pct    = 0;    // chance per cycle that the sender idles
    int unsigned rsp_stall_pct  = 0;    // chance per cycle that the receiver stalls

    ir_delivery_code_transmitter_core #(
        .SEGMENTS (SEGMENT_COUNT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Transmitter model: apply one item to the model state and return the
    // result it should produce.
    // ------------------------------------------------------------------
    function automatic rsp_item_t predict_ir_response(cmd_item_t it);
        rsp_item_t         r;
        logic [7:0]        check_byte;
        logic [TICK_W-1:0] seg_ticks;
        r = '0;
        if (it.func == FUNC_REQUEST)
        begin
            // A request only counts on an idle transmitter; otherwise drop it.
            if (!tx.sending)
            begin
                check_byte = ({it.param_d, 4'h0} + {4'h0, it.param_c})
                             ^ {it.param_b, it.param_a};
                tx.code_word = {HEADER_BYTE, it.param_d, it.param_c,
                                it.param_b, it.param_a, check_byte};
                tx.seg_idx        = '0;
                tx.tick_count     = '0;
                tx.carrier_phase  = 1'b0;
                tx.carrier_enable = 1'b1;
                tx.sending        = 1'b1;
                r.accepted        = 1'b1;
            end
        end
        else if (tx.sending)
        begin
            // Toggle the carrier in an on segment, hold it low in an off one.
            if (tx.carrier_enable)
                tx.carrier_phase = ~tx.carrier_phase;
            else
                tx.carrier_phase = 1'b0;
            tx.tick_count = tx.tick_count + 1'b1;

            // Long for a one bit of the word; short for a zero bit and for
            // every segment past the last word bit.
            seg_ticks = seg_len.short_ticks;
            if (tx.seg_idx < WORD_W)
            begin
                if (tx.code_word[tx.seg_idx])
                    seg_ticks = seg_len.long_ticks;
            end

            // A length of zero behaves as one; a wrapped counter also ends it.
            if (tx.tick_count >= seg_ticks || tx.tick_count == '0)
            begin
                tx.tick_count = '0;
                if (tx.seg_idx + 1 >= SEGMENT_COUNT)
                begin
                    tx.seg_idx        = '0;
                    tx.sending        = 1'b0;
                    tx.carrier_enable = 1'b0;
                    tx.carrier_phase  = 1'b0;
                    r.done_res        = 1'b1;
                end
                else
                begin
                    tx.seg_idx        = tx.seg_idx + 1'b1;
                    tx.carrier_enable = ~tx.carrier_enable;
                    if (!tx.carrier_enable)
                        tx.carrier_phase = 1'b0;
                end
            end
        end
        r.ir_level = tx.carrier_enable & tx.sending & tx.carrier_phase;
        r.busy_res = tx.sending;
        return r;
    endfunction

    task automatic compare_bit(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", field, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Edge monitor: track register writes, predict each accepted item and
    // check each delivered result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_item_t want;
        rsp_item_t got;
        logic      was_sending;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LONG_TICKS:  seg_len.long_ticks  = cfg_wdata;
                CFG_SHORT_TICKS: seg_len.short_ticks = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd_ch.valid && cmd_ch.ready)
        begin
            was_sending = tx.sending;
            pending_responses.push_back(predict_ir_response(cmd_ch.data));
            // Count only items that start a code or move one along.
            if ((cmd_ch.data.func == FUNC_TICK) == was_sending)
                live_items++;
        end

        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_responses.size() == 0)
            begin
                $error("result with no item outstanding: %b", got);
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                compare_bit("ir_level", want.ir_level, got.ir_level);
                compare_bit("busy_res", want.busy_res, got.busy_res);
                compare_bit("accepted", want.accepted, got.accepted);
                compare_bit("done_res", want.done_res, got.done_res);
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    // Watchdog: abandon the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------
    function automatic cmd_item_t make_cmd(logic f, logic [NIB_W-1:0] a, logic [NIB_W-1:0] b,
                                           logic [NIB_W-1:0] c, logic [NIB_W-1:0] d);
        cmd_item_t it;
        it.func    = f;
        it.param_a = a;
        it.param_b = b;
        it.param_c = c;
        it.param_d = d;
        return it;
    endfunction

    function automatic cmd_item_t random_cmd(logic f);
        return make_cmd(f, NIB_W'($urandom), NIB_W'($urandom),
                        NIB_W'($urandom), NIB_W'($urandom));
    endfunction

    // Offer one item, idling first at random, and hold it until taken.
    // Valid stays high on return so back-to-back items need no gap.
    task automatic send_item(input cmd_item_t it);
        while ($urandom_range(99) < cmd_gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted result has arrived.
    task automatic wait_for_responses();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_responses.size() != 0);
    endtask

    // Write both segment lengths on consecutive cycles.
    task automatic program_segment_lengths(input logic [TICK_W-1:0] long_len,
                                           input logic [TICK_W-1:0] short_len);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LONG_TICKS;
        cfg_wdata <= long_len;
        @(negedge clk);
        cfg_index <= CFG_SHORT_TICKS;
        cfg_wdata <= short_len;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic tick_until_idle();
        while (tx.sending)
            send_item(random_cmd(FUNC_TICK));
    endtask

    task automatic run_random_phase(input int unsigned n,
                                    input logic [TICK_W-1:0] long_len,
                                    input logic [TICK_W-1:0] short_len);
        int unsigned goal;
        int unsigned halfway;
        bit          reprogrammed;
        logic        is_request;
        goal         = live_items + n;
        halfway      = live_items + n / 2;
        reprogrammed = 1'b0;
        wait_for_responses();
        program_segment_lengths(long_len, short_len);
        while (live_items < goal)
        begin
            // Midway, drain completely and move to fresh segment lengths.
            if (!reprogrammed && live_items >= halfway)
            begin
                reprogrammed = 1'b1;
                wait_for_responses();
                program_segment_lengths(TICK_W'($urandom_range(6, 1)),
                                        TICK_W'($urandom_range(4, 1)));
            end
            // Mostly well-formed traffic: requests on an idle block, ticks
            // on a busy one; the rest is ignored noise.
            if (tx.sending)
                is_request = ($urandom_range(99) < 5);
            else
                is_request = ($urandom_range(99) < 85);
            send_item(random_cmd(is_request ? FUNC_REQUEST : FUNC_TICK));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks on an idle block change nothing and keep the LED low.
    task automatic test_idle_ticks();
        send_item(make_cmd(FUNC_TICK, 4'hF, 4'hF, 4'hF, 4'hF));
        send_item(make_cmd(FUNC_TICK, 4'h0, 4'h0, 4'h0, 4'h0));
    endtask

    // A full code with all-zero nibbles, with a request while busy that must
    // be dropped; runs through the short segment beyond the last word bit.
    task automatic test_full_code();
        wait_for_responses();
        program_segment_lengths(16'd2, 16'd1);
        send_item(make_cmd(FUNC_REQUEST, 4'h0, 4'h0, 4'h0, 4'h0));
        send_item(make_cmd(FUNC_TICK, 4'h0, 4'h0, 4'h0, 4'h0));
        send_item(make_cmd(FUNC_REQUEST, 4'hF, 4'hF, 4'hF, 4'hF));
        tick_until_idle();
    endtask

    // Zero lengths act as one tick per segment.
    task automatic test_zero_lengths();
        wait_for_responses();
        program_segment_lengths(16'd0, 16'd0);
        send_item(make_cmd(FUNC_REQUEST, 4'hF, 4'hF, 4'hF, 4'hF));
        tick_until_idle();
    endtask

    // Largest lengths, then shrink them mid-segment so the counter is
    // already past the new length. a = 1 gives a long first segment and a
    // short second one.
    task automatic test_longest_segments();
        wait_for_responses();
        program_segment_lengths(16'hFFFF, 16'hFFFF);
        send_item(make_cmd(FUNC_REQUEST, 4'h1, 4'h0, 4'h0, 4'h0));
        repeat (12)
            send_item(random_cmd(FUNC_TICK));
        wait_for_responses();
        program_segment_lengths(16'd2, 16'hFFFF);
        repeat (12)
            send_item(random_cmd(FUNC_TICK));
        wait_for_responses();
        program_segment_lengths(16'd2, 16'd1);
        tick_until_idle();
    endtask

    task automatic test_random_receiver_stalls();
        cmd_gap_pct   = 19;
        rsp_stall_pct = 76;
        run_random_phase(115, TICK_W'($urandom_range(6, 1)), TICK_W'($urandom_range(4, 1)));
    endtask

    task automatic test_random_sender_gaps();
        cmd_gap_pct   = 76;
        rsp_stall_pct = 19;
        run_random_phase(115, TICK_W'($urandom_range(6, 1)), TICK_W'($urandom_range(4, 1)));
    endtask

    // Full rate both ways, starting from the shortest lengths.
    task automatic test_random_full_rate();
        cmd_gap_pct   = 0;
        rsp_stall_pct = 0;
        run_random_phase(115, 16'd1, 16'd1);
    endtask

    initial
    begin
        // Initialise every input and the model before the first edge.
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_LONG_TICKS;
        cfg_wdata    = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        tx           = '0;
        seg_len.long_ticks  = LONG_TICKS_RST;
        seg_len.short_ticks = SHORT_TICKS_RST;

        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;

        cmd_gap_pct   = 19;
        rsp_stall_pct = 76;
        test_idle_ticks();
        test_full_code();
        test_zero_lengths();
        test_longest_segments();
        test_random_receiver_stalls();
        test_random_sender_gaps();
        test_random_full_rate();

        wait_for_responses();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
